### rtl/bis_pkg.sv
package bis_pkg;

  // field and datapath widths fixed by the number formats
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned MAG_W    = 17;
  localparam int unsigned TERM_W   = 31;
  localparam int unsigned MEAN_W   = 31;
  localparam int unsigned ROOT_W   = 28;
  localparam int unsigned RAD_W    = 2 * ROOT_W;
  localparam int unsigned SQREM_W  = ROOT_W + 3;
  localparam int unsigned PROD_W   = ROOT_W + MAG_W;
  localparam int unsigned SCORE_W  = 32;
  localparam int unsigned IDX_W    = 20;
  localparam int unsigned BLEN_W   = 13;
  localparam int unsigned FRAC_W   = 12;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [MAG_W-1:0]   Q12_ONE    = MAG_W'(4096);
  localparam logic [SCORE_W-1:0] SCORE_MAX  = '1;
  localparam logic [63:0]        ROUND_HALF = 64'(2048);

  // register map, by word index
  localparam logic [1:0] REG_SCORE_MODE  = 2'd0;
  localparam logic [1:0] REG_BLOCK_LEN   = 2'd1;
  localparam logic [1:0] REG_ACT_PRESENT = 2'd2;

  localparam logic [BLEN_W-1:0] BLOCK_LEN_RST = BLEN_W'(256);

  typedef struct packed {
    logic              score_mode;
    logic [BLEN_W-1:0] block_length;
    logic              activations_present;
  } cfg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] weight;
    logic signed [WORD_W-1:0] partner_value;
    logic                     tensor_end;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   block_index;
    logic [SCORE_W-1:0] score;
    logic               final_block;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic mul;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic closes;
    logic iter_last;
    logic fisher;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SQI,
    ST_SQRT,
    ST_MUL,
    ST_HOLD
  } state_e;

  // two's complement magnitude, -32768 gives 32768
  function automatic logic [MAG_W-1:0] mag16(logic [WORD_W-1:0] v);
    logic [MAG_W-1:0] ext;
    ext = {v[WORD_W-1], v};
    return v[WORD_W-1] ? (MAG_W'(0) - ext) : ext;
  endfunction

endpackage

### rtl/block_importance_scorer.sv
// Block importance scorer.
// Input channel (in_valid_i/in_ready_o, in_item_i) takes one weight and one
// partner value per beat; the stream is cut into blocks of block_length
// elements, and tensor_end closes a short last block. Output channel
// (out_valid_o/out_ready_i, out_item_o) carries one score beat per block.
// Configuration goes through the APB port (score_mode at 0x0, block_length
// at 0x4, activations_present at 0x8); the user must write it only while
// idle, since the block does not enforce this. Elements that do not close
// a block are taken one per cycle. A closing element starts a per-block
// pass through a shared bit-serial divider and, in fisher mode, a
// bit-serial square root and a multiply; input is held off during that
// pass. The score beat is loaded into the output register once the pass
// is done and the register is free.
// The result sits in an output register, so a stalled receiver does not
// block further accumulation; only the next block close waits for it.
// Reset clears the accumulator, block counter and output valid, and loads
// the register defaults (magnitude mode, length 256, activations present).
module block_importance_scorer #(
  parameter int unsigned MAX_BLOCK_LEN = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bis_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bis_pkg::out_item_t           out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bis_pkg::PADDR_W-1:0]  paddr,
  input  logic [bis_pkg::PDATA_W-1:0]  pwdata,
  output logic [bis_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import bis_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  bis_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bis_datapath #(
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

  bis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

endmodule

### rtl/bis_regs.sv
module bis_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bis_pkg::PADDR_W-1:0]  paddr,
  input  logic [bis_pkg::PDATA_W-1:0]  pwdata,
  output logic [bis_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output bis_pkg::cfg_t                cfg_o
);
  import bis_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SCORE_MODE:  cfg_d.score_mode          = pwdata[0];
        REG_BLOCK_LEN:   cfg_d.block_length        = pwdata[BLEN_W-1:0];
        REG_ACT_PRESENT: cfg_d.activations_present = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_mode          <= 1'b0;
      cfg_q.block_length        <= BLOCK_LEN_RST;
      cfg_q.activations_present <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_SCORE_MODE:  prdata = PDATA_W'(cfg_q.score_mode);
      REG_BLOCK_LEN:   prdata = PDATA_W'(cfg_q.block_length);
      REG_ACT_PRESENT: prdata = PDATA_W'(cfg_q.activations_present);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/bis_datapath.sv
module bis_datapath #(
  parameter int unsigned MAX_BLOCK_LEN = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bis_pkg::cfg_t        cfg_i,
  input  bis_pkg::in_item_t    in_item_i,
  input  bis_pkg::ctrl_cmd_t   cmd_i,
  output bis_pkg::dp_status_t  status_o,
  output bis_pkg::out_item_t   out_item_o
);
  import bis_pkg::*;

  localparam int unsigned SUM_W  = TERM_W + $clog2(MAX_BLOCK_LEN);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCK_LEN + 1);
  localparam int unsigned DREM_W = CNT_W + 1;
  localparam int unsigned ITER_W = $clog2(SUM_W + 1);

  logic [MAG_W-1:0]    wm, pm, op_a, op_b;
  logic [2*MAG_W-1:0]  term_full;
  logic [CNT_W-1:0]    cnt_inc;
  logic [31:0]         bl32, eff32;

  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    cnt_q, den_q;
  logic [MAG_W-1:0]    fwm_q;
  logic                end_q, fin_q;
  logic [IDX_W-1:0]    blk_q, idx_q;
  logic [SUM_W-1:0]    dvd_q;
  logic [DREM_W-1:0]   drem_q, drem_sh;
  logic                dge;
  logic [ITER_W-1:0]   iter_q;
  logic [RAD_W-1:0]    rad_q;
  logic [SQREM_W-1:0]  srem_q, srem_sh, trial;
  logic                sge;
  logic [ROOT_W-1:0]   root_q;
  logic [PROD_W-1:0]   prod_q;
  logic [63:0]         q64, r64;
  logic [SCORE_W-1:0]  score;
  out_item_t           out_q;

  // per-element term: one shared multiplier
  assign wm        = mag16(in_item_i.weight);
  assign pm        = mag16(in_item_i.partner_value);
  assign op_a      = cfg_i.score_mode ? pm : wm;
  assign op_b      = (cfg_i.score_mode || cfg_i.activations_present) ? pm : Q12_ONE;
  assign term_full = op_a * op_b;

  // block close test against the clamped length
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign bl32    = 32'(cfg_i.block_length);
  always_comb begin
    if (bl32 == 32'd0) begin
      eff32 = 32'd1;
    end else if (bl32 > 32'(MAX_BLOCK_LEN)) begin
      eff32 = 32'(MAX_BLOCK_LEN);
    end else begin
      eff32 = bl32;
    end
  end

  // divider step, one quotient bit per cycle
  assign drem_sh = {drem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
  assign dge     = drem_sh >= {1'b0, den_q};

  // square root step, one root bit per cycle
  assign srem_sh = {srem_q[SQREM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial   = SQREM_W'({root_q, 2'b01});
  assign sge     = srem_sh >= trial;

  // accumulator and block bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      fwm_q <= '0;
      end_q <= 1'b0;
      blk_q <= '0;
      idx_q <= '0;
      fin_q <= 1'b0;
    end else if (cmd_i.accept) begin
      sum_q <= sum_q + SUM_W'(term_full[TERM_W-1:0]);
      cnt_q <= cnt_inc;
      end_q <= in_item_i.tensor_end;
      if (cnt_q == '0) begin
        fwm_q <= wm;
      end
    end else if (cmd_i.prep) begin
      sum_q <= '0;
      cnt_q <= '0;
      idx_q <= blk_q;
      fin_q <= end_q;
      blk_q <= end_q ? '0 : blk_q + IDX_W'(1);
    end
  end

  // divide and square root iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      den_q  <= '0;
      drem_q <= '0;
      iter_q <= '0;
      rad_q  <= '0;
      srem_q <= '0;
      root_q <= '0;
      prod_q <= '0;
    end else begin
      if (cmd_i.prep) begin
        dvd_q  <= sum_q + SUM_W'(cnt_q >> 1);
        den_q  <= cnt_q;
        drem_q <= '0;
        iter_q <= ITER_W'(SUM_W - 1);
      end else if (cmd_i.div_step) begin
        dvd_q  <= {dvd_q[SUM_W-2:0], dge};
        drem_q <= dge ? (drem_sh - {1'b0, den_q}) : drem_sh;
        iter_q <= iter_q - ITER_W'(1);
      end else if (cmd_i.sqrt_init) begin
        rad_q  <= RAD_W'({dvd_q[MEAN_W-1:0], 24'd0});
        srem_q <= '0;
        root_q <= '0;
        iter_q <= ITER_W'(ROOT_W - 1);
      end else if (cmd_i.sqrt_step) begin
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        srem_q <= sge ? (srem_sh - trial) : srem_sh;
        root_q <= {root_q[ROOT_W-2:0], sge};
        iter_q <= iter_q - ITER_W'(1);
      end
      if (cmd_i.mul) begin
        prod_q <= root_q * fwm_q;
      end
    end
  end

  // score select with rounding and saturation
  assign q64 = 64'(dvd_q);
  assign r64 = (64'(prod_q) + ROUND_HALF) >> FRAC_W;
  always_comb begin
    if (cfg_i.score_mode) begin
      score = (r64[63:SCORE_W] != '0) ? SCORE_MAX : r64[SCORE_W-1:0];
    end else begin
      score = (q64[63:SCORE_W] != '0) ? SCORE_MAX : q64[SCORE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.block_index <= idx_q;
      out_q.score       <= score;
      out_q.final_block <= fin_q;
    end
  end

  assign out_item_o         = out_q;
  assign status_o.closes    = in_item_i.tensor_end || (32'(cnt_inc) >= eff32);
  assign status_o.iter_last = iter_q == '0;
  assign status_o.fisher    = cfg_i.score_mode;

endmodule

### rtl/bis_ctrl.sv
module bis_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  bis_pkg::dp_status_t  status_i,
  output bis_pkg::ctrl_cmd_t   cmd_o
);
  import bis_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.closes) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.iter_last) begin
          state_d = status_i.fisher ? ST_SQI : ST_HOLD;
        end
      end
      ST_SQI: begin
        cmd_o.sqrt_init = 1'b1;
        state_d         = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.iter_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_close_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && status_i.closes) |=> state_q == ST_PREP)
    else $error("closing beat did not start the divide");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !status_i.iter_last) |=> state_q == ST_DIV)
    else $error("divide left early");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> (out_valid_q && state_q == ST_IDLE))
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule

### tb/sv/block_importance_scorer_tb.sv
module block_importance_scorer_tb;
  import bis_pkg::*;

  // expected-score store and block predictor
  class score_board;
    out_item_t        pending_q[$];
    logic             mode;
    logic [BLEN_W-1:0] blen;
    logic             act_on;
    longint unsigned  acc_sum;
    int unsigned      elem_cnt;
    int unsigned      lead_mag;
    int unsigned      blk_idx;
    int               errors;
    int               items_seen;
    int               scores_seen;
    int               fisher_scores;

    function new();
      mode = 1'b0;
      blen = BLEN_W'(256);
      act_on = 1'b1;
      acc_sum = 0;
      elem_cnt = 0;
      lead_mag = 0;
      blk_idx = 0;
      errors = 0;
      items_seen = 0;
      scores_seen = 0;
      fisher_scores = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function int unsigned magnitude(logic signed [WORD_W-1:0] v);
      int x;
      x = int'(v);
      return (x < 0) ? -x : x;
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // accepted input beat: accumulate and maybe close a block
    function void note_input(in_item_t it);
      int unsigned wm;
      int unsigned pm;
      int unsigned lim;
      longint unsigned mean;
      longint unsigned sc;
      out_item_t exp_item;
      items_seen++;
      wm = magnitude(it.weight);
      pm = magnitude(it.partner_value);
      if (!mode) acc_sum += longint'(wm) * (act_on ? pm : 4096);
      else acc_sum += longint'(pm) * pm;
      if (elem_cnt == 0) lead_mag = wm;
      elem_cnt++;
      lim = (blen == 0) ? 1 : ((blen > 4096) ? 4096 : blen);
      if (!it.tensor_end && elem_cnt < lim) return;
      mean = (acc_sum + (elem_cnt >> 1)) / elem_cnt;
      if (!mode) begin
        sc = mean;
      end else begin
        sc = (int_root(mean << 24) * lead_mag + 2048) >> 12;
        fisher_scores++;
      end
      if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
      exp_item.block_index = IDX_W'(blk_idx);
      exp_item.score = sc[31:0];
      exp_item.final_block = it.tensor_end;
      pending_q.push_back(exp_item);
      acc_sum = 0;
      elem_cnt = 0;
      lead_mag = 0;
      blk_idx = it.tensor_end ? 0 : ((blk_idx + 1) & 32'hFFFFF);
    endfunction

    // accepted score beat against the oldest expectation
    task check_result(out_item_t got);
      out_item_t want;
      scores_seen++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected score beat idx=%0d", got.block_index));
        return;
      end
      want = pending_q.pop_front();
      if (got.block_index !== want.block_index)
        report($sformatf("block_index %0d, want %0d", got.block_index, want.block_index));
      if (got.score !== want.score)
        report($sformatf("score %h, want %h (idx %0d)", got.score, want.score,
                         want.block_index));
      if (got.final_block !== want.final_block)
        report($sformatf("final_block %b, want %b (idx %0d)", got.final_block,
                         want.final_block, want.block_index));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  score_board sb = new();
  bit no_idle = 1'b0;
  int hold_left = 0;
  int cycle_cnt = 0;

  localparam int CYCLE_LIMIT = 1000000;

  block_importance_scorer u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // beat monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(in_item_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // score receiver with random stalls and long hold-offs
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready_i <= no_idle ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  // register write then read back, starts and ends at a falling edge
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == REG_BLOCK_LEN) ? 32'h1FFF : 32'h1;
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (val & mask))
      sb.report($sformatf("readback reg %0d = %h, want %h", idx, prdata, val & mask));
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    case (idx)
      REG_SCORE_MODE:  sb.mode = val[0];
      REG_BLOCK_LEN:   sb.blen = val[BLEN_W-1:0];
      REG_ACT_PRESENT: sb.act_on = val[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // valid stays high between back-to-back beats
  task automatic send_item(in_item_t it);
    if (!no_idle) begin
      while ($urandom_range(99) < 11) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // drop valid and let every outstanding score drain
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t mk(logic [15:0] w, logic [15:0] p, logic e);
    in_item_t it;
    it.weight = w;
    it.partner_value = p;
    it.tensor_end = e;
    return it;
  endfunction

  task automatic run_random(int n, int end_pct);
    repeat (n) send_item(mk(pick_word(), pick_word(), $urandom_range(99) < end_pct));
  endtask

  task automatic phase(logic m, logic [12:0] len, logic act, int n, int end_pct);
    reg_write(REG_SCORE_MODE, m);
    reg_write(REG_BLOCK_LEN, len);
    reg_write(REG_ACT_PRESENT, act);
    run_random(n, end_pct);
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes in magnitude mode, one beat per block
    reg_write(REG_BLOCK_LEN, 13'd1);
    send_item(mk(16'h8000, 16'h8000, 1'b0));
    send_item(mk(16'h7FFF, 16'h7FFF, 1'b0));
    send_item(mk(16'h8000, 16'h7FFF, 1'b1));
    send_item(mk(16'h0000, 16'hFFFF, 1'b0));
    drain();
    // activations absent
    reg_write(REG_ACT_PRESENT, 1'b0);
    send_item(mk(16'h8000, 16'h1234, 1'b0));
    send_item(mk(16'hFFFF, 16'h0000, 1'b1));
    drain();
    // fisher mode, length zero acts as one
    reg_write(REG_SCORE_MODE, 1'b1);
    reg_write(REG_BLOCK_LEN, 13'd0);
    send_item(mk(16'h8000, 16'h8000, 1'b0));
    send_item(mk(16'h7FFF, 16'h8000, 1'b0));
    send_item(mk(16'h0001, 16'h0001, 1'b1));
    drain();
    // length lowered mid-block
    reg_write(REG_BLOCK_LEN, 13'd256);
    repeat (5) send_item(mk(pick_word(), pick_word(), 1'b0));
    drain();
    reg_write(REG_BLOCK_LEN, 13'd2);
    send_item(mk(16'h4000, 16'h2000, 1'b0));
    drain();
    // mode changed mid-block, then tensor end closes a short block
    reg_write(REG_BLOCK_LEN, 13'd8);
    repeat (3) send_item(mk(pick_word(), pick_word(), 1'b0));
    drain();
    reg_write(REG_SCORE_MODE, 1'b0);
    reg_write(REG_ACT_PRESENT, 1'b1);
    send_item(mk(16'h7FFF, 16'h8000, 1'b0));
    send_item(mk(16'h1000, 16'h1000, 1'b1));
    drain();

    // random phases across settings, extremes of block length included
    phase(1'b0, 13'd1, 1'b1, 120, 20);
    phase(1'b1, 13'd2, 1'b1, 120, 10);
    phase(1'b0, 13'd3, 1'b0, 120, 10);
    phase(1'b1, 13'd7, 1'b0, 140, 5);
    no_idle = 1'b1;
    phase(1'b0, 13'd4, 1'b1, 160, 5);
    no_idle = 1'b0;
    phase(1'b1, 13'd16, 1'b1, 150, 3);
    phase(1'b0, 13'd8191, 1'b1, 100, 3);
    phase(1'b1, 13'd4096, 1'b0, 60, 0);
    phase(1'b0, 13'd2, 1'b1, 120, 8);

    // receiver holds off while input keeps coming, block fills up
    reg_write(REG_SCORE_MODE, 1'b0);
    reg_write(REG_BLOCK_LEN, 13'd1);
    hold_left = 400;
    run_random(60, 10);
    drain();
    phase(1'b1, 13'd1, 1'b1, 100, 10);
    phase(1'b0, 13'd5, 1'b0, 150, 10);

    $display("covered %0d input beats and %0d score beats (%0d fisher)",
             sb.items_seen, sb.scores_seen, sb.fisher_scores);
    $display("block lengths 0 to 8191, both modes, activations on and off, stalls");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
